@@ rtl/core/numeric_literal_parser_core_macros.svh @@
// Assertion macros shared by the numeric literal parser RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef NUMERIC_LITERAL_PARSER_CORE_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_CORE_MACROS_SVH

// Check a property on every clock edge outside of reset.
`define NLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define NLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/core/nlp_pkg.sv @@
// Package of the numeric literal parser: character codes and the
// character class struct. Depends on nothing.
`default_nettype none

package nlp_pkg;

  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;
  localparam logic [7:0] CHAR_UP_A   = 8'h41;
  localparam logic [7:0] CHAR_UP_F   = 8'h46;
  localparam logic [7:0] CHAR_UP_H   = 8'h48;
  localparam logic [7:0] CHAR_UP_X   = 8'h58;
  localparam logic [7:0] CHAR_LO_A   = 8'h61;
  localparam logic [7:0] CHAR_LO_F   = 8'h66;
  localparam logic [7:0] CHAR_LO_H   = 8'h68;
  localparam logic [7:0] CHAR_LO_X   = 8'h78;

  // Offset that maps the low three bits of a-f / A-F onto 10..15.
  localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

  typedef struct packed {
    logic       is_minus;
    logic       is_zero;
    logic       is_dec;
    logic       is_hex;
    logic       is_h;
    logic       is_x;
    logic [3:0] digit;
  } char_class_t;

endpackage

`default_nettype wire

@@ rtl/core/nlp_if.sv @@
// Valid/ready channel interfaces of the numeric literal parser.
// Depends on nothing.
`default_nettype none

interface nlp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  logic       signed_mode;

  modport source (output valid, output char_code, output last_char,
                  output signed_mode, input ready);
  modport sink   (input valid, input char_code, input last_char,
                  input signed_mode, output ready);
endinterface

interface nlp_out_if #(
  parameter int VALUE_WIDTH = 16
);
  logic                   valid;
  logic                   ready;
  logic                   valid_res;
  logic [VALUE_WIDTH-1:0] value_bits;

  modport source (output valid, output valid_res, output value_bits, input ready);
  modport sink   (input valid, input valid_res, input value_bits, output ready);
endinterface

`default_nettype wire

@@ rtl/core/nlp_char_decode.sv @@
// Character classifier: sorts one ASCII code into digit classes and
// gives its digit value. Depends on nlp_pkg.
`default_nettype none

module nlp_char_decode (
  input  wire logic [7:0]          char_code_i,
  output nlp_pkg::char_class_t     cls_o
);
  import nlp_pkg::*;

  always_comb begin
    cls_o          = '0;
    cls_o.is_minus = (char_code_i == CHAR_MINUS);
    cls_o.is_zero  = (char_code_i == CHAR_ZERO);
    cls_o.is_dec   = char_code_i inside {[CHAR_ZERO:CHAR_NINE]};
    cls_o.is_h     = (char_code_i == CHAR_LO_H) || (char_code_i == CHAR_UP_H);
    cls_o.is_x     = (char_code_i == CHAR_LO_X) || (char_code_i == CHAR_UP_X);
    if (cls_o.is_dec) begin
      cls_o.is_hex = 1'b1;
      cls_o.digit  = char_code_i[3:0];
    end else if (char_code_i inside {[CHAR_LO_A:CHAR_LO_F], [CHAR_UP_A:CHAR_UP_F]}) begin
      cls_o.is_hex = 1'b1;
      cls_o.digit  = {1'b0, char_code_i[2:0]} + HEX_LETTER_OFFSET;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nlp_token_ctrl.sv @@
// Per-token state of the parser: accumulators, position and form flags,
// and the result of the token's final character. Depends on nlp_pkg.
`default_nettype none

module nlp_token_ctrl #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   step_i,
  input  nlp_pkg::char_class_t        cls_i,
  input  wire logic                   last_i,
  input  wire logic                   sgn_i,
  output logic                        emit_o,
  output logic                        res_valid_o,
  output logic [VALUE_WIDTH-1:0]      res_value_o
);
  import nlp_pkg::*;

  logic [VALUE_WIDTH-1:0] dec_q, dec_d, hex_q, hex_d;
  logic [1:0]             pos_q, pos_d;
  logic                   fz_q, fz_d, hasx_q, hasx_d;
  logic                   alld_q, alld_d, hexok_q, hexok_d, neg_q, neg_d;
  logic                   take_minus, x_pref;
  logic [VALUE_WIDTH-1:0] sel_value;

  assign take_minus = (pos_q == 2'd0) && !neg_q && sgn_i && cls_i.is_minus;
  assign x_pref     = (pos_q == 2'd1) && fz_q && cls_i.is_x;

  // Body update of all state for one character.
  always_comb begin
    dec_d   = dec_q;
    hex_d   = hex_q;
    pos_d   = pos_q;
    fz_d    = fz_q;
    hasx_d  = hasx_q;
    alld_d  = alld_q;
    hexok_d = hexok_q;
    neg_d   = neg_q;
    if (take_minus) begin
      neg_d = 1'b1;
    end else begin
      if (cls_i.is_dec) begin
        dec_d = {dec_q[VALUE_WIDTH-4:0], 3'b000} + {dec_q[VALUE_WIDTH-2:0], 1'b0}
              + VALUE_WIDTH'(cls_i.digit);
      end else begin
        alld_d = 1'b0;
      end
      if (cls_i.is_hex) begin
        hex_d = {hex_q[VALUE_WIDTH-5:0], cls_i.digit};
      end
      if (x_pref) begin
        hasx_d = 1'b1;
      end else if (!cls_i.is_hex) begin
        hexok_d = 1'b0;
      end
      if (pos_q == 2'd0) begin
        fz_d = cls_i.is_zero;
      end
      if (pos_q != 2'd3) begin
        pos_d = pos_q + 2'd1;
      end
    end
  end

  // Result of the final character.
  always_comb begin
    res_valid_o = 1'b0;
    sel_value   = '0;
    if (take_minus) begin
      res_valid_o = 1'b1;
    end else if (hasx_q && (pos_q >= 2'd2)) begin
      res_valid_o = hexok_d;
      sel_value   = hex_d;
    end else if ((pos_q >= 2'd1) && cls_i.is_h) begin
      res_valid_o = hexok_q;
      sel_value   = hex_d;
    end else begin
      res_valid_o = alld_d;
      sel_value   = dec_d;
    end
    if (!res_valid_o) begin
      res_value_o = '0;
    end else if (neg_q) begin
      res_value_o = '0 - sel_value;
    end else begin
      res_value_o = sel_value;
    end
  end

  assign emit_o = step_i && last_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dec_q   <= '0;
      hex_q   <= '0;
      pos_q   <= 2'd0;
      fz_q    <= 1'b0;
      hasx_q  <= 1'b0;
      alld_q  <= 1'b1;
      hexok_q <= 1'b1;
      neg_q   <= 1'b0;
    end else if (emit_o) begin
      dec_q   <= '0;
      hex_q   <= '0;
      pos_q   <= 2'd0;
      fz_q    <= 1'b0;
      hasx_q  <= 1'b0;
      alld_q  <= 1'b1;
      hexok_q <= 1'b1;
      neg_q   <= 1'b0;
    end else if (step_i) begin
      dec_q   <= dec_d;
      hex_q   <= hex_d;
      pos_q   <= pos_d;
      fz_q    <= fz_d;
      hasx_q  <= hasx_d;
      alld_q  <= alld_d;
      hexok_q <= hexok_d;
      neg_q   <= neg_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/numeric_literal_parser_core.sv @@
// Top level of the numeric literal parser core.
// Depends on nlp_pkg, nlp_if, nlp_char_decode, nlp_token_ctrl and the macro header.
`default_nettype none
`include "numeric_literal_parser_core_macros.svh"

// The core reads one numeric token as a stream of ASCII characters, one
// character per input transfer, with last_char set on the final one. In
// signed mode (sampled on the first character) a leading minus is removed
// and applied at the end as a two's complement negation. The body is parsed
// as C hex ("0x"/"0X" plus hex digits), assembler hex (hex digits closed by
// h/H) or plain decimal; accumulators wrap modulo 2^VALUE_WIDTH. Exactly one
// result transfer follows each final character: valid_res and value_bits,
// with value_bits zero for a malformed token and a lone minus reading as a
// valid zero. Each character is parsed combinationally: the classifier
// and the accumulator update (a shift-and-add multiply by ten and a nibble
// shift) sit between the token state registers and the result register, so
// a new character can be taken on every clock. The result register frees
// itself in the same cycle it is read, so input stalls only while a result
// waits on a stalled output and another character is offered.
module numeric_literal_parser_core #(
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  nlp_in_if.sink        in_i,
  nlp_out_if.source     out_o
);
  import nlp_pkg::*;

  char_class_t            cls;
  logic                   in_fire;
  logic                   emit;
  logic                   res_valid;
  logic [VALUE_WIDTH-1:0] res_value;

  logic                   out_vld_q, out_vld_d;
  logic                   out_res_q;
  logic [VALUE_WIDTH-1:0] out_val_q;

  // Input is taken whenever the result register is empty or being drained.
  assign in_i.ready = !out_vld_q || out_o.ready;
  assign in_fire    = in_i.valid && in_i.ready;

  nlp_char_decode u_decode (
    .char_code_i (in_i.char_code),
    .cls_o       (cls)
  );

  nlp_token_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .cls_i       (cls),
    .last_i      (in_i.last_char),
    .sgn_i       (in_i.signed_mode),
    .emit_o      (emit),
    .res_valid_o (res_valid),
    .res_value_o (res_value)
  );

  // A new result loads the register; otherwise a completed output
  // transfer empties it.
  always_comb begin
    out_vld_d = out_vld_q;
    if (emit) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_res_q <= res_valid;
      out_val_q <= res_value;
    end
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.valid_res  = out_res_q;
  assign out_o.value_bits = out_val_q;

  // A final character always produces a pending result.
  `NLP_ASSERT(a_last_gives_result, in_fire && in_i.last_char |=> out_vld_q, "final character lost")
  // With the result register empty the core never stalls its input.
  `NLP_ASSERT(a_ready_when_empty, !out_vld_q |-> in_i.ready, "input stalled while empty")
  // A non-final character never creates a result on its own.
  `NLP_ASSERT(a_no_spurious_result, in_fire && !in_i.last_char |=> out_vld_q == $past(out_vld_q && !out_o.ready), "spurious result")

endmodule

`default_nettype wire

@@ dv/numeric_literal_parser_core_tb.sv @@
// Self-checking testbench for numeric_literal_parser_core: a token-level parse predictor
// and scoreboard, plus character and result drivers. Depends on nlp_pkg, nlp_if and the RTL.
`timescale 1ns / 100ps

// Tracks the parse state of the token in flight. It predicts the result of every
// token whose last character is accepted, and compares the results the block returns.
class literal_scoreboard #(int VW = 16);
  typedef struct packed {
    logic          valid_res;
    logic [VW-1:0] value_bits;
  } parse_result_t;

  parse_result_t pending[$];
  int unsigned   errors;
  int unsigned   valid_tokens;
  int unsigned   malformed_tokens;

  // Parse state of the current token.
  logic [VW-1:0] dec_acc;
  logic [VW-1:0] hex_acc;
  logic [1:0]    body_pos;
  bit            first_zero;
  bit            x_prefix;
  bit            all_dec;
  bit            hex_ok;
  bit            negative;

  function new();
    errors = 0;
    valid_tokens = 0;
    malformed_tokens = 0;
    clear_token();
  endfunction

  function void clear_token();
    dec_acc    = '0;
    hex_acc    = '0;
    body_pos   = '0;
    first_zero = 1'b0;
    x_prefix   = 1'b0;
    all_dec    = 1'b1;
    hex_ok     = 1'b1;
    negative   = 1'b0;
  endfunction

  task report(string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  // Called for every accepted character; queues a result on the last one.
  function void note_char(logic [7:0] c, bit last, bit sgn);
    parse_result_t r;
    logic [3:0]    nib;
    logic [1:0]    p;
    bit            is_dec;
    bit            is_hexd;
    bit            is_h;
    bit            is_x;
    bit            hex_before;
    if (body_pos == 2'd0 && !negative && sgn && c == nlp_pkg::CHAR_MINUS) begin
      // A leading minus is stripped; on its own it reads as a valid zero.
      negative = 1'b1;
      if (!last) return;
      r.valid_res  = 1'b1;
      r.value_bits = '0;
    end else begin
      p       = body_pos;
      is_dec  = (c >= nlp_pkg::CHAR_ZERO && c <= nlp_pkg::CHAR_NINE);
      is_hexd = 1'b1;
      if (is_dec) begin
        nib = 4'(c - nlp_pkg::CHAR_ZERO);
      end else if (c >= nlp_pkg::CHAR_LO_A && c <= nlp_pkg::CHAR_LO_F) begin
        nib = 4'(c - nlp_pkg::CHAR_LO_A + 8'd10);
      end else if (c >= nlp_pkg::CHAR_UP_A && c <= nlp_pkg::CHAR_UP_F) begin
        nib = 4'(c - nlp_pkg::CHAR_UP_A + 8'd10);
      end else begin
        is_hexd = 1'b0;
        nib     = '0;
      end
      is_h       = (c == nlp_pkg::CHAR_LO_H || c == nlp_pkg::CHAR_UP_H);
      is_x       = (c == nlp_pkg::CHAR_LO_X || c == nlp_pkg::CHAR_UP_X);
      hex_before = hex_ok;

      if (is_dec) dec_acc = dec_acc * VW'(10) + VW'(nib);
      else all_dec = 1'b0;
      if (is_hexd) hex_acc = (hex_acc << 4) | VW'(nib);

      if (p == 2'd1 && first_zero && is_x) x_prefix = 1'b1;
      else if (!is_hexd) hex_ok = 1'b0;
      if (p == 2'd0) first_zero = (c == nlp_pkg::CHAR_ZERO);
      if (body_pos != 2'd3) body_pos++;

      if (!last) return;

      if (x_prefix && p >= 2'd2) begin
        r.valid_res  = hex_ok;
        r.value_bits = hex_acc;
      end else if (p >= 2'd1 && is_h) begin
        r.valid_res  = hex_before;
        r.value_bits = hex_acc;
      end else begin
        r.valid_res  = all_dec;
        r.value_bits = dec_acc;
      end
      if (r.valid_res && negative) r.value_bits = '0 - r.value_bits;
    end
    if (!r.valid_res) r.value_bits = '0;
    if (r.valid_res) valid_tokens++;
    else malformed_tokens++;
    pending.push_back(r);
    clear_token();
  endfunction

  task check_result(logic vr, logic [VW-1:0] vb);
    parse_result_t exp_r;
    if (pending.size() == 0) begin
      report($sformatf("result with nothing expected: valid_res=%b value_bits=%h", vr, vb));
      return;
    end
    exp_r = pending.pop_front();
    if (vr !== exp_r.valid_res)
      report($sformatf("valid_res=%b, expected %b", vr, exp_r.valid_res));
    if (vb !== exp_r.value_bits)
      report($sformatf("value_bits=%h, expected %h", vb, exp_r.value_bits));
  endtask
endclass

module numeric_literal_parser_core_tb;
  import nlp_pkg::*;

  localparam int VW = 16;
  // Cycles with no transfer on either channel before the run is declared hung.
  // The slowest legal stretch is a receiver stall at 63 percent, far below this.
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_CHARS = 900;

  logic clk_i = 1'b0;
  logic rst_ni;

  nlp_in_if            in_if ();
  nlp_out_if #(.VALUE_WIDTH(VW)) out_if ();

  numeric_literal_parser_core #(.VALUE_WIDTH(VW)) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  literal_scoreboard #(VW) board;

  // Percent of cycles in which each side holds back; changed per phase.
  int unsigned src_idle_pct;
  int unsigned sink_idle_pct;
  int unsigned chars_sent;
  int unsigned results_seen;
  int unsigned stall_cycles;

  // Characters of the next token, first character at index 0.
  logic [7:0] token_chars[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The receiver draws a fresh ready every cycle, so stalls land on every
  // phase of the block's work, including the cycle a result first appears.
  always @(posedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Monitor and watchdog. Both channels are sampled at the rising edge, before
  // the nonblocking updates of that edge land, so the sampled values are the
  // ones that the transfer at this edge actually carried.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready)
        board.note_char(in_if.char_code, in_if.last_char, in_if.signed_mode);
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        board.check_result(out_if.valid_res, out_if.value_bits);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

  // Offers one character and returns at the edge where it is accepted. The
  // valid stays high on return so back-to-back characters leave no gap.
  task automatic send_char(logic [7:0] c, bit last, bit sgn);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.char_code   <= c;
    in_if.last_char   <= last;
    in_if.signed_mode <= sgn;
    do @(posedge clk_i); while (!in_if.ready);
    chars_sent++;
  endtask

  // Sends token_chars as one token. The signed mode only matters on the first
  // character, so the later ones carry a random value.
  task automatic send_token(bit sgn_first);
    foreach (token_chars[i])
      send_char(token_chars[i], i == token_chars.size() - 1,
                (i == 0) ? sgn_first : 1'($urandom_range(1)));
  endtask

  task automatic send_text(string s, bit sgn_first);
    token_chars.delete();
    for (int i = 0; i < s.len(); i++) token_chars.push_back(s[i]);
    send_token(sgn_first);
  endtask

  // Holds the sender off until every queued result has been returned, then
  // lets the output register settle. The queue is first read after the next
  // edge, once the monitor has noted the last transfer.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic logic [7:0] rand_hex_char();
    int unsigned d = $urandom_range(15);
    if (d < 10) return CHAR_ZERO + 8'(d);
    return ($urandom_range(1) ? CHAR_LO_A : CHAR_UP_A) + 8'(d - 10);
  endfunction

  function automatic logic [7:0] rand_dec_char();
    return CHAR_ZERO + 8'($urandom_range(9));
  endfunction

  // Builds a random token into token_chars. Most tokens are well formed in one
  // of the three notations, so that the hex and prefix paths are reached; the
  // rest are a lone minus or zero, raw noise, or well-formed tokens with one character spoiled.
  function automatic void build_random_token();
    int unsigned form = $urandom_range(99);
    int unsigned len;
    int unsigned idx;
    token_chars.delete();
    if ($urandom_range(3) == 0) token_chars.push_back(CHAR_MINUS);
    if (form < 30) begin
      // Plain decimal; now and then long enough to wrap the accumulator.
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      repeat (len) token_chars.push_back(rand_dec_char());
    end else if (form < 55) begin
      token_chars.push_back(CHAR_ZERO);
      token_chars.push_back($urandom_range(1) ? CHAR_LO_X : CHAR_UP_X);
      repeat ($urandom_range(0, 5)) token_chars.push_back(rand_hex_char());
    end else if (form < 75) begin
      repeat ($urandom_range(1, 5)) token_chars.push_back(rand_hex_char());
      token_chars.push_back($urandom_range(1) ? CHAR_LO_H : CHAR_UP_H);
    end else if (form < 80) begin
      // Lone minus, or a lone zero when no minus was drawn.
      if (token_chars.size() == 0) token_chars.push_back(CHAR_ZERO);
    end else if (form < 90) begin
      repeat ($urandom_range(1, 6)) token_chars.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(1, 5)) token_chars.push_back(rand_dec_char());
      idx = $urandom_range(token_chars.size() - 1);
      token_chars[idx] = 8'($urandom_range(255));
    end
  endfunction

  initial begin
    board = new();
    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.char_code   <= '0;
    in_if.last_char   <= 1'b0;
    in_if.signed_mode <= 1'b0;
    src_idle_pct  = 32;
    sink_idle_pct = 63;
    chars_sent    = 0;
    results_seen  = 0;
    stall_cycles  = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed tokens: lone minus, single digit, a bare "0x" prefix, C hex in
    // upper case, negative assembler hex, the shortest assembler hex, a minus
    // in unsigned mode, an h inside the body, a prefix followed only by h,
    // and the two extreme character codes.
    send_text("-", 1'b1);
    send_text("9", 1'b0);
    send_text("0x", 1'b0);
    send_text("0XfA", 1'b1);
    send_text("-ffh", 1'b1);
    send_text("1h", 1'b0);
    send_text("-5", 1'b0);
    send_text("1h2", 1'b0);
    send_text("0xh", 1'b1);
    token_chars.delete();
    token_chars.push_back(8'hFF);
    send_token(1'b1);
    token_chars.delete();
    token_chars.push_back(8'h00);
    send_token(1'b0);

    // Random tokens in three idling phases. Between phases the sender waits
    // for the scoreboard to empty, which also exercises a fully idle block.
    while (chars_sent < RANDOM_CHARS) begin
      if (chars_sent >= 2 * RANDOM_CHARS / 3 && src_idle_pct != 0) begin
        drain_results();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (chars_sent >= RANDOM_CHARS / 3 && src_idle_pct == 32) begin
        drain_results();
        src_idle_pct  = 63;
        sink_idle_pct = 32;
      end
      build_random_token();
      send_token($urandom_range(3) != 0);
    end

    drain_results();
    if (board.pending.size() != 0)
      board.report($sformatf("%0d results never returned", board.pending.size()));
    $display("Covered %0d characters in %0d tokens: %0d well formed, %0d malformed.",
             chars_sent, results_seen, board.valid_tokens, board.malformed_tokens);
    $display("Tokens spanned decimal, 0x hex and h-suffix hex, with and without a minus.");
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
